// ----- hdl/bsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsr_pkg
// shared widths, limits and register indexes of the bmp stream to rgb565 unit
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int HEADER_LENGTH = 54;

    localparam int BYTE_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int ADDR_W   = 20;
    localparam int SIZE_W   = 32;
    localparam int HCNT_W   = 6;
    localparam int DIM_W    = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int COL_W    = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // packed output word: color, address, zero fill to whole bytes
    localparam int OUT_BITS   = COLOR_W + ADDR_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // header byte positions of width and height
    localparam int WIDTH_POS  = 18;
    localparam int HEIGHT_POS = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE = 1'd1;

    localparam logic [COLOR_W-1:0] KEY_COLOR_RST = 16'hF01E;

endpackage

// ----- hdl/bmp_stream_to_rgb565_unit.sv -----
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565_unit
// decodes a 24-bit bmp byte stream into addressed rgb565 pixel words
// ----------------------------------------------------------------------------
// usage
//   slave side takes one file byte per word in tdata, tuser high on the
//   first byte of a file. master side gives one word per pixel (color and
//   address in tdata, tlast on address zero) or a single error word with
//   tuser high when the header size is zero or too large.
//   the key color registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_wdata while the stream is idle.
// timing
//   one byte per clock sustained while the master side is ready; a pixel
//   word reaches the master side after the red byte is taken: the byte
//   first sits in the input register, then the word is held in the result
//   register. the input register and result register together let a new
//   byte in while a finished word still waits.
// reset and stall
//   reset empties both registers, returns to the header and loads the
//   default key. a stall on the master side holds the result word; the
//   slave side stops only once the input register is also full.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb565_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [bsr_pkg::BYTE_W-1:0]           s_axis_tdata,   // data_byte
    input  logic                                 s_axis_tuser,   // start_flag
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [bsr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // pixel_color, pixel_address, zero fill
    output logic                                 m_axis_tlast,   // last_pixel
    output logic                                 m_axis_tuser,   // size_error
    input  logic                                 i_cfg_we,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bsr_pkg::CFG_DAT_W-1:0]        i_cfg_wdata
);
    import bsr_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_IDLE
    } t_phase;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_start;

    logic                r_out_valid;
    logic [COLOR_W-1:0]  r_out_color;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_last;
    logic                r_out_err;

    logic [COLOR_W-1:0]  r_key_color;
    logic                r_key_enable;

    t_phase              r_phase,  n_phase;
    logic [HCNT_W-1:0]   r_hcnt,   n_hcnt;
    logic [SIZE_W-1:0]   r_width,  n_width;
    logic [SIZE_W-1:0]   r_height, n_height;
    logic [ADDR_W-1:0]   r_left,   n_left;
    logic [COL_W-1:0]    r_col,    n_col;
    logic [1:0]          r_chan,   n_chan;
    logic [4:0]          r_blue,   n_blue;
    logic [5:0]          r_green,  n_green;
    logic [1:0]          r_pad,    n_pad;

    logic                advance;
    logic                res_valid;
    logic [COLOR_W-1:0]  res_color;
    logic [ADDR_W-1:0]   res_addr;
    logic                res_last;
    logic                res_err;

    t_phase              cur_phase;
    logic [HCNT_W-1:0]   cur_hcnt;
    logic [HCNT_W-1:0]   hofs_w;
    logic [HCNT_W-1:0]   hofs_h;
    logic [2*DIM_W-1:0]  area;
    logic [COL_W:0]      col_inc;
    logic                size_bad;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, r_out_addr, r_out_color};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    assign hofs_w = r_hcnt - HCNT_W'(WIDTH_POS);
    assign hofs_h = r_hcnt - HCNT_W'(HEIGHT_POS);
    assign area   = r_width[DIM_W-1:0] * r_height[DIM_W-1:0];
    assign col_inc = {1'b0, r_col} + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_width  = r_width;
        n_height = r_height;
        n_left   = r_left;
        n_col    = r_col;
        n_chan   = r_chan;
        n_blue   = r_blue;
        n_green  = r_green;
        n_pad    = r_pad;
        res_valid = 1'b0;
        res_color = '0;
        res_addr  = '0;
        res_last  = 1'b0;
        res_err   = 1'b0;
        size_bad  = 1'b0;
        cur_phase = r_in_start ? PH_HEADER : r_phase;
        cur_hcnt  = r_in_start ? '0 : r_hcnt;
        if (r_in_start) begin
            n_phase  = PH_HEADER;
            n_width  = '0;
            n_height = '0;
        end

        unique case (cur_phase)
            PH_HEADER: begin
                if (cur_hcnt >= HCNT_W'(WIDTH_POS) && cur_hcnt < HCNT_W'(HEIGHT_POS)) begin
                    n_width[8*hofs_w[1:0] +: 8] = r_in_byte;
                end else if (cur_hcnt >= HCNT_W'(HEIGHT_POS)
                             && cur_hcnt < HCNT_W'(HEIGHT_POS + 4)) begin
                    n_height[8*hofs_h[1:0] +: 8] = r_in_byte;
                end
                size_bad = (n_width == '0) || (n_height == '0)
                        || (n_width > SIZE_W'(MAX_WIDTH)) || (n_height > SIZE_W'(MAX_HEIGHT));
                if (cur_hcnt == HCNT_W'(HEADER_LENGTH - 1)) begin
                    n_hcnt = '0;
                    if (size_bad) begin
                        n_phase   = PH_IDLE;
                        res_valid = 1'b1;
                        res_err   = 1'b1;
                    end else begin
                        n_phase = PH_PIXEL;
                        n_left  = ADDR_W'(area - 1'b1);
                        n_col   = '0;
                        n_chan  = '0;
                        n_pad   = '0;
                    end
                end else begin
                    n_hcnt = cur_hcnt + 1'b1;
                end
            end
            PH_PIXEL: begin
                case (r_chan)
                    2'd0: begin
                        n_blue = r_in_byte[7:3];
                        n_chan = 2'd1;
                    end
                    2'd1: begin
                        n_green = r_in_byte[7:2];
                        n_chan  = 2'd2;
                    end
                    default: begin
                        n_chan    = '0;
                        res_valid = 1'b1;
                        res_color = {r_in_byte[7:3], r_green, r_blue};
                        if (r_key_enable && res_color == r_key_color) begin
                            res_color = '0;
                        end
                        res_addr = r_left;
                        res_last = (r_left == '0);
                        if (res_last) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_left = r_left - 1'b1;
                            n_col  = col_inc[COL_W-1:0];
                            if (col_inc >= (COL_W+1)'(r_width[DIM_W-1:0])) begin
                                n_col = '0;
                                n_pad = r_width[1:0];
                                if (r_width[1:0] != 2'd0) begin
                                    n_phase = PH_PAD;
                                end
                            end
                        end
                    end
                endcase
            end
            PH_PAD: begin
                n_pad = r_pad - 1'b1;
                if (r_pad <= 2'd1) begin
                    n_pad   = '0;
                    n_phase = PH_PIXEL;
                end
            end
            PH_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_key_color  <= KEY_COLOR_RST;
            r_key_enable <= 1'b1;
            r_phase      <= PH_HEADER;
            r_hcnt       <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_left       <= '0;
            r_col        <= '0;
            r_chan       <= '0;
            r_pad        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_COLOR:  r_key_color  <= i_cfg_wdata;
                    CFG_KEY_ENABLE: r_key_enable <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && res_valid;
            end
            if (advance && r_in_valid) begin
                r_phase  <= n_phase;
                r_hcnt   <= n_hcnt;
                r_width  <= n_width;
                r_height <= n_height;
                r_left   <= n_left;
                r_col    <= n_col;
                r_chan   <= n_chan;
                r_pad    <= n_pad;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        if (advance && r_in_valid) begin
            r_blue  <= n_blue;
            r_green <= n_green;
            if (res_valid) begin
                r_out_color <= res_color;
                r_out_addr  <= res_addr;
                r_out_last  <= res_last;
                r_out_err   <= res_err;
            end
        end
    end

endmodule

// ----- hdl/bsr_checker.sv -----
// ----------------------------------------------------------------------------
// bsr_checker
// port level checks of the bmp stream to rgb565 unit
// ----------------------------------------------------------------------------
module bsr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bsr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           m_axis_tuser
);
    import bsr_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // error word carries no pixel
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
        else $error("error word carries pixel data");

    // last pixel sits at address zero
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[OUT_BITS-1:COLOR_W] == '0)
        else $error("last pixel not at address zero");

    // empty output side never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind bmp_stream_to_rgb565_unit bsr_checker u_bsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
